@@ rtl/rsp_pkg.sv @@
package rsp_pkg;

    // Width of the internal accumulator; the result is sign-extended or
    // truncated to the 32-bit output field.
    localparam int VALUE_BITS = 32;
    localparam int OUT_W      = 32;
    localparam int CH_W       = 8;
    localparam int DIGIT_W    = 4;

    // Character codes the parser recognises.
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_UPA   = 8'h41;
    localparam logic [CH_W-1:0] CH_UPF   = 8'h46;
    localparam logic [CH_W-1:0] CH_UPX   = 8'h58;
    localparam logic [CH_W-1:0] CH_LOWX  = 8'h78;

    // Value of the letter A as a hex digit.
    localparam logic [DIGIT_W-1:0] HEX_A_VAL = 4'd10;

    // Parse phase of the current string.
    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_BASE   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_FIRST  = 3'd3,
        PH_DIGITS = 3'd4,
        PH_BAD    = 3'd5
    } t_phase;

    // Selected number base.
    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_OCT = 2'd1,
        RX_HEX = 2'd2
    } t_radix;

    // Character held in the input register, passed to the parser core.
    typedef struct packed {
        logic            valid;
        logic [CH_W-1:0] ch;
    } t_char_req;

endpackage

@@ rtl/rsp_in_stage.sv @@
module rsp_in_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rsp_pkg::CH_W-1:0]   i_ch,
    input  logic                       i_ch_valid,
    output logic                       o_ch_ready,
    input  logic                       i_take,
    output rsp_pkg::t_char_req         o_req
);

    logic                     r_valid;
    logic [rsp_pkg::CH_W-1:0] r_ch;
    logic                     load;

    // The register can take a new request when empty or being drained.
    assign o_ch_ready = !r_valid || i_take;
    assign load       = i_ch_valid && o_ch_ready;

    // Valid flag of the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Character payload; needs no reset.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ch <= i_ch;
        end
    end

    assign o_req.valid = r_valid;
    assign o_req.ch    = r_ch;

endmodule

@@ rtl/rsp_core.sv @@
module rsp_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rsp_pkg::t_char_req               i_req,
    output logic                             o_take,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output logic signed [rsp_pkg::OUT_W-1:0] o_value,
    output logic                             o_status
);

    localparam int VB = rsp_pkg::VALUE_BITS;

    // Parser state.
    rsp_pkg::t_phase r_phase, n_phase;
    rsp_pkg::t_radix r_radix, n_radix;
    logic            r_neg, n_neg;
    logic [VB-1:0]   r_accum, n_accum;

    // Result register.
    logic                             r_out_valid;
    logic signed [rsp_pkg::OUT_W-1:0] r_value;
    logic                             r_status;

    logic [rsp_pkg::CH_W-1:0]    c;
    logic                        fire;
    logic                        is_nul;
    logic                        is_space;
    logic                        is_x;
    logic                        first_path;
    rsp_pkg::t_radix             eff_radix;
    logic                        dig_ok;
    logic [rsp_pkg::DIGIT_W-1:0] dig_val;
    logic [VB-1:0]               acc_scaled;
    logic                        res_fire;
    logic                        res_ok;
    logic signed [VB-1:0]        signed_acc;
    logic signed [rsp_pkg::OUT_W-1:0] res_value;

    assign c        = i_req.ch;
    assign fire     = i_req.valid && (!r_out_valid || i_res_ready);
    assign o_take   = fire;
    assign is_nul   = (c == rsp_pkg::CH_NUL);
    assign is_space = (c == rsp_pkg::CH_SPACE);
    assign is_x     = (c == rsp_pkg::CH_UPX) || (c == rsp_pkg::CH_LOWX);

    // Characters that go straight to first-digit handling, and the base
    // that applies to them.
    always_comb begin
        first_path = 1'b0;
        eff_radix  = r_radix;
        case (r_phase)
            rsp_pkg::PH_LEAD: begin
                first_path = !is_space && !is_nul && (c != rsp_pkg::CH_MINUS)
                             && (c != rsp_pkg::CH_ZERO);
                eff_radix  = rsp_pkg::RX_DEC;
            end
            rsp_pkg::PH_BASE: begin
                first_path = (c != rsp_pkg::CH_ZERO);
                eff_radix  = rsp_pkg::RX_DEC;
            end
            rsp_pkg::PH_ZERO: begin
                first_path = !is_space && !is_nul && !is_x;
                eff_radix  = rsp_pkg::RX_OCT;
            end
            rsp_pkg::PH_FIRST: begin
                first_path = 1'b1;
            end
            default: begin
                first_path = 1'b0;
            end
        endcase
    end

    // Digit decode for the effective base; hex letters are uppercase only.
    always_comb begin
        dig_ok  = 1'b0;
        dig_val = '0;
        if (c >= rsp_pkg::CH_ZERO && c <= rsp_pkg::CH_SEVEN) begin
            dig_ok  = 1'b1;
            dig_val = rsp_pkg::DIGIT_W'(c - rsp_pkg::CH_ZERO);
        end else if (c > rsp_pkg::CH_SEVEN && c <= rsp_pkg::CH_NINE
                     && eff_radix != rsp_pkg::RX_OCT) begin
            dig_ok  = 1'b1;
            dig_val = rsp_pkg::DIGIT_W'(c - rsp_pkg::CH_ZERO);
        end else if (c >= rsp_pkg::CH_UPA && c <= rsp_pkg::CH_UPF
                     && eff_radix == rsp_pkg::RX_HEX) begin
            dig_ok  = 1'b1;
            dig_val = rsp_pkg::DIGIT_W'(c - rsp_pkg::CH_UPA) + rsp_pkg::HEX_A_VAL;
        end
    end

    // Accumulator times the base, built from shifts and one add.
    always_comb begin
        case (r_radix)
            rsp_pkg::RX_OCT: acc_scaled = r_accum << 3;
            rsp_pkg::RX_HEX: acc_scaled = r_accum << 4;
            default:         acc_scaled = (r_accum << 3) + (r_accum << 1);
        endcase
    end

    // Next-state logic of the parser.
    always_comb begin
        n_phase = r_phase;
        n_radix = r_radix;
        n_neg   = r_neg;
        n_accum = r_accum;
        if (fire) begin
            if (is_nul) begin
                // The terminator always returns the parser to its idle state.
                n_phase = rsp_pkg::PH_LEAD;
                n_radix = rsp_pkg::RX_DEC;
                n_neg   = 1'b0;
                n_accum = '0;
            end else if (first_path) begin
                n_radix = eff_radix;
                n_phase = rsp_pkg::PH_FIRST;
                if (!is_space) begin
                    if (dig_ok) begin
                        n_accum = VB'(dig_val);
                        n_phase = rsp_pkg::PH_DIGITS;
                    end else begin
                        n_phase = rsp_pkg::PH_BAD;
                    end
                end
            end else begin
                case (r_phase)
                    rsp_pkg::PH_LEAD: begin
                        if (c == rsp_pkg::CH_MINUS) begin
                            n_neg   = 1'b1;
                            n_phase = rsp_pkg::PH_BASE;
                        end else if (c == rsp_pkg::CH_ZERO) begin
                            n_phase = rsp_pkg::PH_ZERO;
                        end
                    end
                    rsp_pkg::PH_BASE: begin
                        n_phase = rsp_pkg::PH_ZERO;
                    end
                    rsp_pkg::PH_ZERO: begin
                        if (is_x) begin
                            n_radix = rsp_pkg::RX_HEX;
                            n_phase = rsp_pkg::PH_FIRST;
                        end
                    end
                    rsp_pkg::PH_DIGITS: begin
                        if (!is_space) begin
                            if (dig_ok) begin
                                n_accum = acc_scaled + VB'(dig_val);
                            end else begin
                                n_phase = rsp_pkg::PH_BAD;
                            end
                        end
                    end
                    default: begin
                        n_phase = rsp_pkg::PH_BAD;
                    end
                endcase
            end
        end
    end

    // Result logic: one result per terminator.
    always_comb begin
        res_fire   = fire && is_nul;
        res_ok     = (r_phase == rsp_pkg::PH_ZERO) || (r_phase == rsp_pkg::PH_DIGITS);
        signed_acc = r_neg ? signed'(VB'(0) - r_accum) : signed'(r_accum);
        res_value  = res_ok ? rsp_pkg::OUT_W'(signed_acc) : '0;
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rsp_pkg::PH_LEAD;
            r_radix <= rsp_pkg::RX_DEC;
            r_neg   <= 1'b0;
            r_accum <= '0;
        end else begin
            r_phase <= n_phase;
            r_radix <= n_radix;
            r_neg   <= n_neg;
            r_accum <= n_accum;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (res_fire) begin
            r_value  <= res_value;
            r_status <= !res_ok;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;

endmodule

@@ rtl/radix_integer_string_parser_top.sv @@
// Channel   Valid        Ready        Payload
// input     i_ch_valid   o_ch_ready   i_ch (8-bit character, zero ends the string)
// result    o_res_valid  i_res_ready  o_value (32-bit signed), o_status (1 bit)
//
// One character is accepted per cycle while o_ch_ready is high. A character is parsed
// as the core takes it from the input register; a terminator's result is registered
// onto o_res_valid. The parse step is a single pass of digit decode and shift-add.
// Reset is synchronous and active low; it returns the parser to leading-space skip.
// While a result waits with i_res_ready low, the parser holds every character, the
// input register fills and o_ch_ready stays low until the result is taken.
module radix_integer_string_parser_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [rsp_pkg::CH_W-1:0]         i_ch,
    input  logic                             i_ch_valid,
    output logic                             o_ch_ready,
    output logic signed [rsp_pkg::OUT_W-1:0] o_value,
    output logic                             o_status,
    output logic                             o_res_valid,
    input  logic                             i_res_ready
);

    rsp_pkg::t_char_req req;
    logic               take;

    // Input register.
    rsp_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ch       (i_ch),
        .i_ch_valid (i_ch_valid),
        .o_ch_ready (o_ch_ready),
        .i_take     (take),
        .o_req      (req)
    );

    // Parser state and result register.
    rsp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .o_take      (take),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_value     (o_value),
        .o_status    (o_status)
    );

endmodule
